/* design/vps_pkg.sv */
// Shared types, constants and the word duration ROM of the voice prompt sequencer.
// No dependencies.
package vps_pkg;

  localparam int PHRASE_DEPTH = 32;
  localparam int WORD_COUNT   = 98;
  localparam int ADDR_W       = (PHRASE_DEPTH > 1) ? $clog2(PHRASE_DEPTH) : 1;
  localparam int CNT_W        = $clog2(PHRASE_DEPTH + 1);
  localparam int WORD_W       = 7;
  localparam int TIME_W       = 32;
  localparam int DUR_W        = 14;
  localparam int ROM_ENTRIES  = 97;

  localparam logic [TIME_W-1:0] START_LEAD = 32'd10;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_WORD   = 3'd1,
    EV_DONE   = 3'd2,
    EV_ACCEPT = 3'd3,
    EV_REJECT = 3'd4
  } event_e;

  typedef struct packed {
    logic              command;
    logic [WORD_W-1:0] word;
    logic              last_word;
    logic              transmitting;
    logic [TIME_W-1:0] now_ticks;
    logic              analog_mode;
    logic              rf_amp_active;
    logic              carrier_present;
  } item_t;

  typedef struct packed {
    event_e            event_res;
    logic [WORD_W-1:0] word_code;
    logic              amp_on;
    logic              amp_off;
    logic              led_on;
    logic              led_off;
    logic              mux_to_baseband;
    logic              mux_to_rf;
    logic              speaking;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  localparam logic [DUR_W-1:0] DUR_ROM [ROM_ENTRIES] = '{
    14'd5680, 14'd4620, 14'd4400, 14'd4320, 14'd4360, 14'd6920, 14'd5300, 14'd5460,
    14'd4080, 14'd5340, 14'd4880, 14'd6260, 14'd5980, 14'd6660, 14'd5880, 14'd6440,
    14'd7460, 14'd7540, 14'd6600, 14'd7320, 14'd6920, 14'd6120, 14'd6320, 14'd6680,
    14'd7220, 14'd8060, 14'd6380, 14'd6560, 14'd5420, 14'd7960, 14'd13920, 14'd6000,
    14'd8340, 14'd6100, 14'd6400, 14'd6560, 14'd5440, 14'd6880, 14'd7360, 14'd4700,
    14'd4040, 14'd7360, 14'd5080, 14'd4820, 14'd4500, 14'd4900, 14'd5460, 14'd5560,
    14'd5460, 14'd5500, 14'd5840, 14'd6240, 14'd6440, 14'd5800, 14'd5620, 14'd6840,
    14'd5820, 14'd8820, 14'd15320, 14'd8660, 14'd11560, 14'd4780, 14'd5260, 14'd5840,
    14'd4360, 14'd6180, 14'd5600, 14'd4060, 14'd5240, 14'd4180, 14'd4240, 14'd4280,
    14'd7440, 14'd4440, 14'd5140, 14'd5100, 14'd5120, 14'd4920, 14'd5760, 14'd5740,
    14'd5320, 14'd5840, 14'd8140, 14'd10740, 14'd7340, 14'd6100, 14'd5800, 14'd4320,
    14'd2000, 14'd9800, 14'd6520, 14'd5960, 14'd5940, 14'd5860, 14'd6100, 14'd6060,
    14'd5280
  };

  // Words past the table or past the word count play for zero ticks.
  function automatic logic [DUR_W-1:0] word_duration(input logic [WORD_W-1:0] idx);
    logic [DUR_W-1:0] dur;
    dur = '0;
    if (32'(idx) < ROM_ENTRIES && 32'(idx) < WORD_COUNT) begin
      dur = DUR_ROM[idx];
    end
    return dur;
  endfunction

endpackage

/* design/vps_word_mem.sv */
// Phrase word buffer: one write port, one registered read port.
// A read of the entry written in the same cycle returns the new word.
// Depends on vps_pkg.
module vps_word_mem (
  input  logic                       clk_i,
  input  vps_pkg::mem_wr_t           wr_i,
  input  logic                       rd_en_i,
  input  logic [vps_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [vps_pkg::WORD_W-1:0] rd_data_o
);

  logic [vps_pkg::WORD_W-1:0] mem_q [vps_pkg::PHRASE_DEPTH];
  logic [vps_pkg::WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && wr_i.addr == rd_addr_i) begin
        rd_data_q <= wr_i.data;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/vps_ctrl.sv */
// Sequencer state and per-beat execute logic: phrase load, start, word timing, teardown.
// Depends on vps_pkg.
module vps_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        exec_i,
  input  vps_pkg::item_t              item_i,
  input  logic [vps_pkg::WORD_W-1:0]  rd_word_i,
  output vps_pkg::mem_wr_t            wr_o,
  output logic [vps_pkg::CNT_W-1:0]   pos_next_o,
  output vps_pkg::result_t            res_o
);

  logic [vps_pkg::CNT_W-1:0]  pos_q, pos_d;
  logic [vps_pkg::CNT_W-1:0]  len_q, len_d;
  logic [vps_pkg::CNT_W-1:0]  lcnt_q, lcnt_d;
  logic                       lrej_q, lrej_d;
  logic [vps_pkg::TIME_W-1:0] end_q, end_d;
  logic [vps_pkg::TIME_W-1:0] end_cur;
  logic [vps_pkg::CNT_W-1:0]  lcnt_inc;
  logic                       lrej_inc;

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    lcnt_d   = lcnt_q;
    lrej_d   = lrej_q;
    end_d    = end_q;
    end_cur  = end_q;
    lcnt_inc = lcnt_q;
    lrej_inc = lrej_q;
    wr_o     = '0;
    res_o    = '0;
    res_o.event_res = vps_pkg::EV_NONE;

    if (exec_i) begin
      if (item_i.command == vps_pkg::CMD_LOAD) begin
        if (lcnt_q < vps_pkg::CNT_W'(vps_pkg::PHRASE_DEPTH)) begin
          wr_o.en   = 1'b1;
          wr_o.addr = lcnt_q[vps_pkg::ADDR_W-1:0];
          wr_o.data = item_i.word;
          lcnt_inc  = lcnt_q + 1'b1;
        end else begin
          lrej_inc = 1'b1;
        end
        lcnt_d = lcnt_inc;
        lrej_d = lrej_inc;
        if (item_i.last_word) begin
          if (!item_i.transmitting && !lrej_inc && lcnt_inc != '0 &&
              lcnt_inc <= vps_pkg::CNT_W'(vps_pkg::PHRASE_DEPTH)) begin
            pos_d = '0;
            len_d = lcnt_inc;
            res_o.event_res = vps_pkg::EV_ACCEPT;
          end else begin
            res_o.event_res = vps_pkg::EV_REJECT;
          end
          lcnt_d = '0;
          lrej_d = 1'b0;
        end
      end else if (len_q != '0) begin
        if (pos_q == '0) begin
          res_o.amp_on          = 1'b1;
          res_o.led_on          = 1'b1;
          res_o.mux_to_baseband = item_i.analog_mode;
          end_cur               = item_i.now_ticks - vps_pkg::START_LEAD;
          end_d                 = end_cur;
        end
        if (item_i.now_ticks > end_cur) begin
          if (pos_q >= len_q) begin
            res_o.event_res = vps_pkg::EV_DONE;
            res_o.amp_off   = 1'b1;
            res_o.mux_to_rf = item_i.analog_mode & item_i.rf_amp_active;
            res_o.led_off   = !item_i.rf_amp_active && !item_i.carrier_present;
            len_d           = '0;
          end else begin
            res_o.event_res = vps_pkg::EV_WORD;
            res_o.word_code = rd_word_i;
            end_d = item_i.now_ticks +
                    vps_pkg::TIME_W'(vps_pkg::word_duration(rd_word_i));
            pos_d = pos_q + 1'b1;
          end
        end
      end
    end
    res_o.speaking = (len_d != '0);
  end

  assign pos_next_o = pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      lcnt_q <= '0;
      lrej_q <= 1'b0;
      end_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      lcnt_q <= lcnt_d;
      lrej_q <= lrej_d;
      end_q  <= end_d;
    end
  end

endmodule

/* design/voice_prompt_sequencer.sv */
// Voice prompt sequencer top: input stage, phrase word buffer, execute, output register.
// An accepted beat waits in the input stage; its result goes to the output register.
// Throughput: one beat per cycle unless the output stalls; the buffer read for the next
// beat uses the play position left by the executing beat (write-through on a hit).
// Reset clears position, length, end time and load count; buffer contents are not reset.
// Depends on vps_pkg, vps_word_mem and vps_ctrl.
module voice_prompt_sequencer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [vps_pkg::WORD_W-1:0] word_i,
  input  logic                       last_word_i,
  input  logic                       transmitting_i,
  input  logic [vps_pkg::TIME_W-1:0] now_ticks_i,
  input  logic                       analog_mode_i,
  input  logic                       rf_amp_active_i,
  input  logic                       carrier_present_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 event_res_o,
  output logic [vps_pkg::WORD_W-1:0] word_code_o,
  output logic                       amp_on_o,
  output logic                       amp_off_o,
  output logic                       led_on_o,
  output logic                       led_off_o,
  output logic                       mux_to_baseband_o,
  output logic                       mux_to_rf_o,
  output logic                       speaking_o
);

  vps_pkg::item_t             item_q;
  logic                       item_valid_q;
  vps_pkg::result_t           res, res_q;
  logic                       out_valid_q;
  logic                       exec;
  logic                       accept;
  vps_pkg::mem_wr_t           wr;
  logic [vps_pkg::CNT_W-1:0]  pos_next;
  logic [vps_pkg::WORD_W-1:0] rd_word;

  assign exec       = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !exec;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= accept || (item_valid_q && !exec);
      out_valid_q  <= exec || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.command         <= command_i;
      item_q.word            <= word_i;
      item_q.last_word       <= last_word_i;
      item_q.transmitting    <= transmitting_i;
      item_q.now_ticks       <= now_ticks_i;
      item_q.analog_mode     <= analog_mode_i;
      item_q.rf_amp_active   <= rf_amp_active_i;
      item_q.carrier_present <= carrier_present_i;
    end
    if (exec) begin
      res_q <= res;
    end
  end

  vps_word_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (accept),
    .rd_addr_i (pos_next[vps_pkg::ADDR_W-1:0]),
    .rd_data_o (rd_word)
  );

  vps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .exec_i     (exec),
    .item_i     (item_q),
    .rd_word_i  (rd_word),
    .wr_o       (wr),
    .pos_next_o (pos_next),
    .res_o      (res)
  );

  assign out_valid_o       = out_valid_q;
  assign event_res_o       = res_q.event_res;
  assign word_code_o       = res_q.word_code;
  assign amp_on_o          = res_q.amp_on;
  assign amp_off_o         = res_q.amp_off;
  assign led_on_o          = res_q.led_on;
  assign led_off_o         = res_q.led_off;
  assign mux_to_baseband_o = res_q.mux_to_baseband;
  assign mux_to_rf_o       = res_q.mux_to_rf;
  assign speaking_o        = res_q.speaking;

endmodule
